// ===== hdl/kdwt_pkg.sv =====
`default_nettype none

package kdwt_pkg;

  localparam int unsigned IDX_W   = 4;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned TMO_W   = 32;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd5000;

  // one check beat
  typedef struct packed {
    logic [IDX_W-1:0]   slot_index;
    logic               is_active;
    logic [ID_W-1:0]    ident_first;
    logic [ID_W-1:0]    ident_second;
    logic [PHASE_W-1:0] phase_tag;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic             expired_now;
    logic [IDX_W-1:0] last_expired_slot;
  } out_item_t;

  // stored tuple of one slot
  typedef struct packed {
    logic [ID_W-1:0]    ident_first;
    logic [ID_W-1:0]    ident_second;
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  start_time;
  } slot_entry_t;

endpackage

`default_nettype wire

// ===== hdl/kdwt_slot_store.sv =====
`default_nettype none

module kdwt_slot_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire kdwt_pkg::slot_entry_t wr_data,
  input  wire logic [AW-1:0]         rd_addr,
  output      kdwt_pkg::slot_entry_t rd_data
);

  kdwt_pkg::slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-edge write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/keyed_deadline_watchdog_table_unit.sv =====
`default_nettype none

// keyed deadline watchdog table
// each check beat (start high while busy is low) names a slot, an activity
// flag, a two-word identity, a phase tag and the current time in ms.
// an inactive check disarms the slot; a fresh activation or any change of
// identity or phase rearms it with now_ms as start time; an unchanged armed
// check whose wrapped elapsed time reaches timeout_ms reports expiry and
// latches the slot index. slot indexes at or above SLOT_COUNT change nothing.
// the result beat (done high for one cycle) follows the taken check: the
// slot store is read on the taking edge, compare and update land in the
// result register on the next. one check per cycle while busy is low; a
// check on the slot written by the check just before it is forwarded. the
// user must write timeout_ms through cfg_we/cfg_wdata only while no check
// is in flight; the block does not enforce it. reset (rst, synchronous)
// disarms every slot, clears the expiry latch, loads timeout_ms with 5000
// and holds busy high; busy drops on the edge after rst is released. stored
// tuples need no clearing: they are only read while their slot is armed.
// the receiver cannot stall the result beat, so nothing backs up.
module keyed_deadline_watchdog_table_unit #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire kdwt_pkg::in_item_t item,
  output      logic               done,
  output      kdwt_pkg::out_item_t result,
  input  wire logic               cfg_we,
  input  wire logic [kdwt_pkg::TMO_W-1:0] cfg_wdata
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [6:0] SLOT_LIMIT = 7'(SLOT_COUNT);

  // configuration
  logic [kdwt_pkg::TMO_W-1:0] timeout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= kdwt_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  wire logic accept = start && !busy;

  // stage 1: captured check, slot store read in flight
  logic               s1_valid;
  kdwt_pkg::in_item_t s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  // slot store and its forwarding path
  logic                  wr_en;
  logic [AW-1:0]         s1_addr;
  kdwt_pkg::slot_entry_t wr_data;
  kdwt_pkg::slot_entry_t rd_data;

  kdwt_slot_store #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (wr_data),
    .rd_addr (AW'(item.slot_index)),
    .rd_data (rd_data)
  );

  // last write, which the store read on the same edge did not yet see
  logic                  fwd_valid;
  logic [AW-1:0]         fwd_addr;
  kdwt_pkg::slot_entry_t fwd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr  <= s1_addr;
      fwd_entry <= wr_data;
    end
  end

  // armed flags live in flops, always current
  logic [SLOT_COUNT-1:0] armed;
  logic [SLOT_COUNT-1:0] armed_next;
  logic [kdwt_pkg::IDX_W-1:0] latch;
  logic [kdwt_pkg::IDX_W-1:0] latch_next;

  kdwt_pkg::slot_entry_t            entry;
  logic                             in_range;
  logic                             slot_armed;
  logic                             changed;
  logic [kdwt_pkg::TIME_W-1:0]      elapsed;
  logic                             fire;

  assign s1_addr  = AW'(s1_item.slot_index);
  assign in_range = 7'(s1_item.slot_index) < SLOT_LIMIT;

  always_comb begin
    entry = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_entry : rd_data;
    slot_armed = in_range && armed[s1_addr];
    changed = !slot_armed
           || (entry.ident_first  != s1_item.ident_first)
           || (entry.ident_second != s1_item.ident_second)
           || (entry.phase        != s1_item.phase_tag);
    // 64-bit wrapping elapsed time
    elapsed = s1_item.now_ms - entry.start_time;

    wr_data.ident_first  = s1_item.ident_first;
    wr_data.ident_second = s1_item.ident_second;
    wr_data.phase        = s1_item.phase_tag;
    wr_data.start_time   = s1_item.now_ms;

    armed_next = armed;
    latch_next = latch;
    wr_en      = 1'b0;
    fire       = 1'b0;

    if (s1_valid && in_range) begin
      priority if (!s1_item.is_active) begin
        armed_next[s1_addr] = 1'b0;
      end else if (changed) begin
        armed_next[s1_addr] = 1'b1;
        wr_en = 1'b1;
      end else if (elapsed >= {{(kdwt_pkg::TIME_W - kdwt_pkg::TMO_W){1'b0}}, timeout_ms}) begin
        fire       = 1'b1;
        latch_next = s1_item.slot_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
      latch <= '0;
    end else begin
      armed <= armed_next;
      latch <= latch_next;
    end
  end

  // result register: one beat per check
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result.expired_now       <= fire;
      result.last_expired_slot <= latch_next;
    end
  end

`ifndef SYNTH
  // every result beat comes from a check captured the cycle before
  a_done_follows_check: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("result beat without a check");

  // an expiry names the slot of its own check
  a_expiry_slot: assert property (@(posedge clk) disable iff (rst)
    (done && result.expired_now) |-> (result.last_expired_slot == $past(s1_item.slot_index)))
    else $error("expiry reports wrong slot");

  // only an armed slot can expire
  a_fire_armed: assert property (@(posedge clk) disable iff (rst)
    fire |-> armed[s1_addr])
    else $error("expiry on an unarmed slot");

  // the latch moves only on an expiry
  a_latch_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(latch))
    else $error("latch changed without expiry");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;

  localparam int SLOTS         = 16;
  localparam int SETTLE_CYCLES = 4;   // lets the pipeline empty, plus margin
  localparam int TAIL_CYCLES   = 8;

  // kinds of work the driver pulls from its queue
  typedef enum logic [1:0] {
    OP_CHECK,
    OP_TIMEOUT_WRITE,
    OP_DRAIN
  } op_kind_t;

  typedef struct {
    op_kind_t                             kind;
    kdwt_pkg::in_item_t                   chk;
    logic [kdwt_pkg::TMO_W-1:0]           value;
    int unsigned                          gap;
  } pending_op_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  kdwt_pkg::in_item_t         item = '0;
  logic                       cfg_we = 1'b0;
  logic [kdwt_pkg::TMO_W-1:0] cfg_wdata = '0;
  logic                       busy;
  logic                       done;
  kdwt_pkg::out_item_t        result;

  // work waiting for the driver, and result beats still owed by the block
  pending_op_t         op_q[$];
  kdwt_pkg::out_item_t owed_results[$];
  int                  error_count = 0;
  bit                  idle_on = 1'b1;

  // our own copy of the watchdog table
  logic                       watch_armed [SLOTS];
  kdwt_pkg::slot_entry_t      watch_slots [SLOTS];
  logic [kdwt_pkg::IDX_W-1:0] expiry_latch;
  logic [kdwt_pkg::TMO_W-1:0] timeout_copy;

  keyed_deadline_watchdog_table_unit #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // one check against the table copy: disarm, rearm on a new tuple, or time it out
  function automatic kdwt_pkg::out_item_t predict_check(kdwt_pkg::in_item_t c);
    kdwt_pkg::out_item_t         r;
    kdwt_pkg::slot_entry_t       e;
    logic [kdwt_pkg::TIME_W-1:0] elapsed;
    r.expired_now = 1'b0;
    if (int'(c.slot_index) < SLOTS) begin
      e = watch_slots[c.slot_index];
      if (!c.is_active) begin
        watch_armed[c.slot_index] = 1'b0;
      end else if (!watch_armed[c.slot_index] || e.ident_first != c.ident_first ||
                   e.ident_second != c.ident_second || e.phase != c.phase_tag) begin
        // fresh tuple: restart the deadline from now
        watch_armed[c.slot_index] = 1'b1;
        e.ident_first  = c.ident_first;
        e.ident_second = c.ident_second;
        e.phase        = c.phase_tag;
        e.start_time   = c.now_ms;
        watch_slots[c.slot_index] = e;
      end else begin
        // unchanged tuple: wrapping elapsed time against the timeout
        elapsed = c.now_ms - e.start_time;
        if (elapsed >= {32'd0, timeout_copy}) begin
          expiry_latch  = c.slot_index;
          r.expired_now = 1'b1;
        end
      end
    end
    r.last_expired_slot = expiry_latch;
    return r;
  endfunction

  task automatic queue_check(input logic [kdwt_pkg::IDX_W-1:0] slot, input logic act,
                             input logic [kdwt_pkg::ID_W-1:0] f,
                             input logic [kdwt_pkg::ID_W-1:0] s,
                             input logic [kdwt_pkg::PHASE_W-1:0] ph,
                             input logic [kdwt_pkg::TIME_W-1:0] now);
    pending_op_t op;
    op.kind  = OP_CHECK;
    op.chk   = '{slot_index: slot, is_active: act, ident_first: f,
                 ident_second: s, phase_tag: ph, now_ms: now};
    op.value = '0;
    op.gap   = idle_on ? $urandom_range(0, 8) : 0;
    op_q.push_back(op);
  endtask

  // register writes wait for the block to go quiet
  task automatic queue_timeout_write(input logic [kdwt_pkg::TMO_W-1:0] v);
    pending_op_t op;
    op.kind  = OP_TIMEOUT_WRITE;
    op.chk   = '0;
    op.value = v;
    op.gap   = 0;
    op_q.push_back(op);
  endtask

  // hold off new checks until every owed result has come back
  task automatic queue_drain();
    pending_op_t op;
    op.kind  = OP_DRAIN;
    op.chk   = '0;
    op.value = '0;
    op.gap   = 0;
    op_q.push_back(op);
  endtask

  // driver: one nonblocking update per input per edge, predicted at acceptance
  int unsigned waited = 0;
  int unsigned quiet  = 0;

  always @(posedge clk) begin : driver
    logic                       nxt_start;
    logic                       nxt_we;
    kdwt_pkg::in_item_t         nxt_item;
    logic [kdwt_pkg::TMO_W-1:0] nxt_wdata;
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        watch_armed[k] = 1'b0;
        watch_slots[k] = '0;
      end
      expiry_latch = '0;
      timeout_copy = kdwt_pkg::TIMEOUT_RESET;
      waited = 0;
      quiet  = 0;
    end else begin
      nxt_start = start;
      nxt_item  = item;
      nxt_we    = 1'b0;
      nxt_wdata = cfg_wdata;
      // register write lands at this edge
      if (cfg_we) timeout_copy = cfg_wdata;
      // check beat taken at this edge
      if (start && !busy) begin
        owed_results.push_back(predict_check(item));
        nxt_start = 1'b0;
      end
      if (owed_results.size() == 0 && !start && !cfg_we) quiet++;
      else quiet = 0;
      if (!nxt_start && op_q.size() != 0) begin
        if (waited < op_q[0].gap) begin
          waited++;
        end else if (op_q[0].kind == OP_CHECK) begin
          // back-to-back beats keep start high without a dip
          nxt_start = 1'b1;
          nxt_item  = op_q[0].chk;
          void'(op_q.pop_front());
          waited = 0;
        end else if (quiet >= SETTLE_CYCLES) begin
          if (op_q[0].kind == OP_TIMEOUT_WRITE) begin
            nxt_we    = 1'b1;
            nxt_wdata = op_q[0].value;
          end
          void'(op_q.pop_front());
          waited = 0;
        end
      end
      start     <= nxt_start;
      item      <= nxt_item;
      cfg_we    <= nxt_we;
      cfg_wdata <= nxt_wdata;
    end
  end

  // monitor: every done beat is matched against the oldest owed result
  always @(posedge clk) begin : monitor
    kdwt_pkg::out_item_t want;
    if (!rst && done === 1'b1) begin
      if (owed_results.size() == 0) begin
        $error("result beat with no check outstanding");
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (result.expired_now !== want.expired_now) begin
          $error("expired_now: expected %0d, got %0d", want.expired_now, result.expired_now);
          error_count++;
        end
        if (result.last_expired_slot !== want.last_expired_slot) begin
          $error("last_expired_slot: expected %0d, got %0d",
                 want.last_expired_slot, result.last_expired_slot);
          error_count++;
        end
      end
    end
  end

  // stimulus plan and end of run
  initial begin : stimulus
    logic [kdwt_pkg::ID_W-1:0]    gen_first  [SLOTS];
    logic [kdwt_pkg::ID_W-1:0]    gen_second [SLOTS];
    logic [kdwt_pkg::PHASE_W-1:0] gen_phase  [SLOTS];
    logic [kdwt_pkg::TIME_W-1:0]  gen_now    [SLOTS];
    logic [kdwt_pkg::TMO_W-1:0]   phase_tmo  [7];
    logic [kdwt_pkg::TIME_W-1:0]  tmo64;
    logic [kdwt_pkg::TIME_W-1:0]  delta;
    logic [kdwt_pkg::IDX_W-1:0]   slot;
    int unsigned                  pick;

    // directed: default 5000 ms timeout, boundary exactly at the timeout
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEF, 64'h1, 16'h00A5, 64'd100);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEF, 64'h1, 16'h00A5, 64'd5099);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEF, 64'h1, 16'h00A5, 64'd5100);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEF, 64'h1, 16'h00A5, 64'd6000);
    // each tuple word restarts the deadline on its own
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEE, 64'h1, 16'h00A5, 64'd6000);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEE, 64'h1, 16'h00A5, 64'd11000);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEE, 64'h2, 16'h00A5, 64'd11000);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEE, 64'h2, 16'h5A00, 64'd11001);
    // disarm, then the same tuple arms afresh
    queue_check(4'd0, 1'b0, 64'h0123_4567_89AB_CDEE, 64'h2, 16'h5A00, 64'd19000);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEE, 64'h2, 16'h5A00, 64'd20000);
    // disarm of a slot never armed
    queue_check(4'd15, 1'b0, '1, '1, '1, '1);
    // all-ones tuple, time wraps through zero
    queue_check(4'd15, 1'b1, '1, '1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_check(4'd15, 1'b1, '1, '1, 16'hFFFF, 64'd4999);
    // all-zero tuple, time steps backwards
    queue_check(4'd9, 1'b1, '0, '0, '0, 64'd1000);
    queue_check(4'd9, 1'b1, '0, '0, '0, 64'd999);
    // quiet checks still carry the latched slot
    queue_check(4'd15, 1'b1, '1, '1, 16'hFFFE, 64'd5000);
    queue_check(4'd0, 1'b1, 64'h0123_4567_89AB_CDEE, 64'h2, 16'h5A00, 64'd20001);
    // zero timeout: first unchanged check expires at once
    queue_timeout_write('0);
    queue_check(4'd3, 1'b1, 64'hDEAD_BEEF, 64'h77, 16'h0003, 64'd500);
    queue_check(4'd3, 1'b1, 64'hDEAD_BEEF, 64'h77, 16'h0003, 64'd500);
    // largest timeout
    queue_timeout_write('1);
    queue_check(4'd7, 1'b1, 64'h8000_0000_0000_0000, '0, 16'h8000, 64'd0);
    queue_check(4'd7, 1'b1, 64'h8000_0000_0000_0000, '0, 16'h8000, 64'hFFFF_FFFE);
    queue_check(4'd7, 1'b1, 64'h8000_0000_0000_0000, '0, 16'h8000, 64'hFFFF_FFFF);
    queue_check(4'd7, 1'b1, 64'h8000_0000_0000_0000, '0, 16'h8000, 64'h1_0000_0000);

    // random part: mostly repeated tuples with advancing time, mixed with noise
    for (int k = 0; k < SLOTS; k++) begin
      gen_first[k]  = {$urandom, $urandom};
      gen_second[k] = {$urandom, $urandom};
      gen_phase[k]  = 16'($urandom);
      gen_now[k]    = {$urandom, $urandom};
    end
    phase_tmo[0] = kdwt_pkg::TIMEOUT_RESET;
    phase_tmo[1] = '0;
    phase_tmo[2] = 32'd1;
    phase_tmo[3] = 32'd17;
    phase_tmo[4] = $urandom_range(2, 65535);
    phase_tmo[5] = $urandom;
    phase_tmo[6] = '1;

    foreach (phase_tmo[p]) begin
      queue_timeout_write(phase_tmo[p]);
      tmo64 = {32'd0, phase_tmo[p]};
      for (int n = 0; n < 218; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
        if (n == 109) queue_drain();
        // a few busy slots most of the time, so deadlines actually run out
        slot = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          case ($urandom_range(0, 5))
            0:       delta = tmo64 - 1;
            1:       delta = tmo64;
            2:       delta = tmo64 + 1;
            default: delta = (tmo64 * $urandom_range(0, 40)) / 100;
          endcase
          gen_now[slot] = gen_now[slot] + delta;
          queue_check(slot, 1'b1, gen_first[slot], gen_second[slot], gen_phase[slot],
                      gen_now[slot]);
        end else if (pick < 75) begin
          // change one word of the tuple
          case ($urandom_range(0, 2))
            0:       gen_first[slot]  = gen_first[slot] ^ (64'd1 << $urandom_range(0, 63));
            1:       gen_second[slot] = gen_second[slot] ^ (64'd1 << $urandom_range(0, 63));
            default: gen_phase[slot]  = gen_phase[slot] ^ (16'd1 << $urandom_range(0, 15));
          endcase
          gen_now[slot] = gen_now[slot] + $urandom_range(0, 100);
          queue_check(slot, 1'b1, gen_first[slot], gen_second[slot], gen_phase[slot],
                      gen_now[slot]);
        end else if (pick < 87) begin
          queue_check(slot, 1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                      16'($urandom), {$urandom, $urandom});
        end else if (pick < 95) begin
          gen_first[slot]  = {$urandom, $urandom};
          gen_second[slot] = {$urandom, $urandom};
          gen_phase[slot]  = 16'($urandom);
          gen_now[slot]    = {$urandom, $urandom};
          queue_check(slot, 1'b1, gen_first[slot], gen_second[slot], gen_phase[slot],
                      gen_now[slot]);
        end else begin
          // clock going backwards
          gen_now[slot] = gen_now[slot] - $urandom_range(1, 1000);
          queue_check(slot, 1'b1, gen_first[slot], gen_second[slot], gen_phase[slot],
                      gen_now[slot]);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all work handed over, then every owed beat back, then a short tail
    while (op_q.size() != 0 || start || cfg_we) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("keyed_deadline_watchdog_table_unit test passed");
    end else begin
      $display("keyed_deadline_watchdog_table_unit test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog_limit
    #2_000_000;
    $display("keyed_deadline_watchdog_table_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
